// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the core.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define IOL_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// Same, on the default clock and reset names clk and arst_n.
`define IOL_ASSERT_DFLT(lbl, prop, msg) \
	`IOL_ASSERT(lbl, clk, arst_n, prop, msg)

`endif

// ----- rtl/core/iol_pkg.sv -----
// Types and constants of the indexed ordered list core.
// No dependencies; used by every other file of the block but assert_macros.svh.
package iol_pkg;

	localparam int DEPTH      = 16;
	localparam int WORD_BITS  = 32;
	localparam int IDX_BITS   = $clog2(DEPTH);
	localparam int CNT_BITS   = $clog2(DEPTH + 1);
	localparam int KIND_BITS  = 3;
	localparam int INDEX_BITS = 4;
	localparam int VALUE_BITS = 32;
	localparam int STAT_BITS  = 2;
	localparam int COUNT_BITS = 5;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [CNT_BITS-1:0]  cnt_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_PUSH    = 3'd0,
		KIND_POP     = 3'd1,
		KIND_REMOVE  = 3'd2,
		KIND_INSERT  = 3'd3,
		KIND_REPLACE = 3'd4,
		KIND_GET     = 3'd5
	} kind_e_t;

	typedef enum logic [STAT_BITS-1:0] {
		STAT_OK    = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_EMPTY = 2'd3
	} status_e_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP,
		OP_REMOVE,
		OP_INSERT,
		OP_WRITE,
		OP_READ
	} op_e_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_e_t;

	// controller -> datapath
	typedef struct packed {
		logic      load;
		logic      exec;
		op_e_t     op;
		status_e_t status;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		kind_e_t kind;
		logic    empty;
		logic    full;
		logic    in_range;
		logic    out_busy;
	} dp_stat_t;

endpackage

// ----- rtl/core/iol_if.sv -----
// Request and response channel interfaces of the indexed ordered list core.
// Depends on iol_pkg.
interface iol_req_if import iol_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic [KIND_BITS-1:0]         kind;
	logic [INDEX_BITS-1:0]        index;
	logic signed [VALUE_BITS-1:0] value;

	modport source(output valid, kind, index, value, input ready);
	modport sink(input valid, kind, index, value, output ready);
endinterface

interface iol_rsp_if import iol_pkg::*; ();
	logic                         valid;
	logic                         ready;
	logic signed [VALUE_BITS-1:0] read_value;
	logic [STAT_BITS-1:0]         status;
	logic [COUNT_BITS-1:0]        count;

	modport source(output valid, read_value, status, count, input ready);
	modport sink(input valid, read_value, status, count, output ready);
endinterface

// ----- rtl/core/iol_ctrl.sv -----
// Controller of the indexed ordered list core: capture/execute sequencing
// and request checking. Depends on iol_pkg.
module iol_ctrl import iol_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  logic     out_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_e_t state_q, state_d;
	logic     out_free;

	assign out_free = !stat.out_busy || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.exec   = 1'b0;
		cmd.op     = OP_NONE;
		cmd.status = STAT_OK;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			S_EXEC: begin
				cmd.exec = out_free;
				// full is checked ahead of the index on insert
				unique case (stat.kind) inside
					KIND_PUSH: begin
						if (stat.full) cmd.status = STAT_FULL;
						else           cmd.op     = OP_PUSH;
					end
					KIND_POP: begin
						if (stat.empty) cmd.status = STAT_EMPTY;
						else            cmd.op     = OP_POP;
					end
					KIND_INSERT: begin
						if (stat.full)          cmd.status = STAT_FULL;
						else if (!stat.in_range) cmd.status = STAT_RANGE;
						else                    cmd.op     = OP_INSERT;
					end
					KIND_REMOVE, KIND_REPLACE, KIND_GET: begin
						if (stat.empty)          cmd.status = STAT_EMPTY;
						else if (!stat.in_range) cmd.status = STAT_RANGE;
						else if (stat.kind == KIND_REMOVE)  cmd.op = OP_REMOVE;
						else if (stat.kind == KIND_REPLACE) cmd.op = OP_WRITE;
						else                                cmd.op = OP_READ;
					end
					default: ; // unused kinds: no change, status ok
				endcase
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/core/iol_dpath.sv -----
// Datapath of the indexed ordered list core: request register, shifting
// cell row, count and result register. Depends on iol_pkg.
module iol_dpath import iol_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_cmd_t                     cmd,
	output dp_stat_t                     stat,
	input  logic [KIND_BITS-1:0]         req_kind,
	input  logic [INDEX_BITS-1:0]        req_index,
	input  logic signed [VALUE_BITS-1:0] req_value,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic signed [VALUE_BITS-1:0] read_value,
	output logic [STAT_BITS-1:0]         status,
	output logic [COUNT_BITS-1:0]        count
);

	logic [KIND_BITS-1:0]  kind_q;
	logic [INDEX_BITS-1:0] index_q;
	word_t                 value_q;
	cnt_t                  held_q;
	word_t                 cells_q [DEPTH];

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] rd_q;
	status_e_t             status_q;
	cnt_t                  idx_w;
	cnt_t                  last_w;
	logic [IDX_BITS-1:0]   rd_addr;
	word_t                 rd_word;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= req_kind;
			index_q <= req_index;
			value_q <= WORD_BITS'(req_value);
		end
	end

	assign idx_w  = CNT_BITS'(index_q);
	assign last_w = held_q - cnt_t'(1);

	assign stat.kind     = kind_e_t'(kind_q);
	assign stat.empty    = (held_q == '0);
	assign stat.full     = (held_q == cnt_t'(DEPTH));
	assign stat.in_range = (idx_w < held_q);
	assign stat.out_busy = out_valid_q;

	// single read port: last word for pop, indexed word otherwise
	assign rd_addr = (cmd.op == OP_POP) ? last_w[IDX_BITS-1:0] : idx_w[IDX_BITS-1:0];
	assign rd_word = cells_q[rd_addr];

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		localparam cnt_t POS = CNT_BITS'(g);
		word_t from_above;
		word_t from_below;

		if (g == DEPTH - 1) begin : g_top
			assign from_above = '0;
		end else begin : g_mid
			assign from_above = cells_q[g+1];
		end
		if (g == 0) begin : g_bot
			assign from_below = '0;
		end else begin : g_up
			assign from_below = cells_q[g-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				case (cmd.op)
					OP_PUSH: begin
						if (POS == held_q) cells_q[g] <= value_q;
					end
					OP_REMOVE: begin
						if (POS >= idx_w && POS < last_w) cells_q[g] <= from_above;
					end
					OP_INSERT: begin
						if (POS == idx_w)                       cells_q[g] <= value_q;
						else if (POS > idx_w && POS <= held_q)  cells_q[g] <= from_below;
					end
					OP_WRITE: begin
						if (POS == idx_w) cells_q[g] <= value_q;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
				case (cmd.op)
					OP_PUSH, OP_INSERT: held_q <= held_q + cnt_t'(1);
					OP_POP, OP_REMOVE:  held_q <= last_w;
					default: ;
				endcase
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= cmd.status;
			rd_q     <= (cmd.op == OP_POP || cmd.op == OP_READ) ?
				VALUE_BITS'(rd_word) : '0;
		end
	end

	// held_q is registered already, so the count shown follows the update
	assign out_valid  = out_valid_q;
	assign read_value = rd_q;
	assign status     = status_q;
	assign count      = COUNT_BITS'(held_q);

endmodule

// ----- rtl/core/indexed_ordered_list_core.sv -----
// Top level of the indexed ordered list core.
// Depends on iol_pkg, iol_if, iol_ctrl and iol_dpath.
//
// Bounded ordered list of DEPTH signed words with push, pop, remove at index,
// insert at index (below the count), replace and get. Every request returns
// one response: the word popped or fetched (zero otherwise), a status (ok,
// index out of range, list full, list empty) and the count after the request.
// Refused requests leave the list unchanged. A request is first captured,
// then executed: the whole cell row shifts at once and the response
// register loads. The response register frees the request side: the
// next request is captured while a response still waits, and its execute
// cycle holds until that response is taken.
module indexed_ordered_list_core import iol_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	iol_req_if.sink   req,
	iol_rsp_if.source rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	iol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iol_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_kind   (req.kind),
		.req_index  (req.index),
		.req_value  (req.value),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.read_value (rsp.read_value),
		.status     (rsp.status),
		.count      (rsp.count)
	);

endmodule

// ----- rtl/core/iol_checker.sv -----
// Port-level checks of the indexed ordered list core, bound to the top level.
// Depends on iol_pkg and assert_macros.svh.
`include "assert_macros.svh"

module iol_checker import iol_pkg::*; (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic signed [VALUE_BITS-1:0] rsp_read_value,
	input logic [STAT_BITS-1:0]         rsp_status,
	input logic [COUNT_BITS-1:0]        rsp_count
);

	`IOL_ASSERT_DFLT(a_full_count, rsp_valid && rsp_status == STAT_FULL |-> rsp_count == COUNT_BITS'(DEPTH), "full status with count below capacity")
	`IOL_ASSERT_DFLT(a_empty_count, rsp_valid && rsp_status == STAT_EMPTY |-> rsp_count == '0, "empty status with nonzero count")
	`IOL_ASSERT_DFLT(a_refused_zero, rsp_valid && rsp_status != STAT_OK |-> rsp_read_value == '0, "refused transaction returned a word")
	`IOL_ASSERT_DFLT(a_count_bound, rsp_valid |-> rsp_count <= COUNT_BITS'(DEPTH), "count beyond capacity")
	`IOL_ASSERT_DFLT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) && $stable(rsp_status), "stalled response changed")

endmodule

bind indexed_ordered_list_core iol_checker u_iol_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_read_value (rsp.read_value),
	.rsp_status     (rsp.status),
	.rsp_count      (rsp.count)
);
